@@ hw/rtl/sbp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared constants, types and helpers of the servo frame parser.
// ----------------------------------------------------------------------------
package sbp_pkg;

   localparam logic [7:0] HeaderByte   = 8'h0f;
   localparam logic [7:0] FooterA      = 8'h04;
   localparam logic [7:0] FooterB      = 8'h14;
   localparam logic [7:0] FooterC      = 8'h24;
   localparam logic [7:0] FooterD      = 8'h34;
   localparam int         StoreBytes   = 23;
   localparam int         ChanBytes    = 22;
   localparam int         NumChan      = 16;
   localparam int         ChanBits     = 11;
   localparam int         ChanIdxBits  = 4;
   localparam int         PosBits      = 5;
   localparam int         StoreBits    = StoreBytes * 8;
   localparam int         ChanDataBits = ChanBytes * 8;
   localparam int         FailsafeBit  = 3;
   localparam int         FrameLostBit = 2;
   localparam logic [PosBits-1:0]     FooterPos = PosBits'(StoreBytes);
   localparam logic [ChanIdxBits-1:0] LastChan  = ChanIdxBits'(NumChan - 1);

   // One finished frame handed from the assembler to the result stage.
   typedef struct packed {
      logic                    load;
      logic                    reject;
      logic                    failsafe;
      logic                    link_lost;
      logic [ChanDataBits-1:0] data;
   } frame_type;

   function automatic logic footer_ok(input logic [7:0] b);
      return (b inside {FooterA, FooterB, FooterC, FooterD});
   endfunction

endpackage

@@ hw/rtl/sbp_frame_asm.sv @@
// ----------------------------------------------------------------------------
// sbp_frame_asm
// Header search and frame collection; hands a complete frame on at the footer.
// ----------------------------------------------------------------------------
module sbp_frame_asm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 emit_busy,
   output sbp_pkg::frame_type   frame
);
   import sbp_pkg::*;

   logic                         in_frame_ff, in_frame_in;
   logic [PosBits-1:0]           pos_ff, pos_in;
   logic [StoreBits-1:0]         store_ff, store_in;
   logic                         at_footer;
   logic                         accept;

   assign at_footer = in_frame_ff && (pos_ff == FooterPos);
   // Only the footer byte has to wait for the result stage to drain.
   assign req_ready = !(at_footer && emit_busy);
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      store_in    = store_ff;
      frame       = '0;
      frame.reject     = !footer_ok(req_rx_byte);
      frame.failsafe   = store_ff[ChanDataBits + FailsafeBit];
      frame.link_lost  = store_ff[ChanDataBits + FrameLostBit];
      frame.data       = store_ff[ChanDataBits-1:0];
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == HeaderByte) begin
               in_frame_in = 1'b1;
               pos_in      = '0;
            end
         end else if (!at_footer) begin
            // Bytes enter at the top, so byte 0 ends up in the low bits.
            store_in = {req_rx_byte, store_ff[StoreBits-1:8]};
            pos_in   = pos_ff + PosBits'(1);
         end else begin
            in_frame_in = 1'b0;
            frame.load  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
      store_ff <= store_in;
   end

endmodule

@@ hw/rtl/sbp_emit.sv @@
// ----------------------------------------------------------------------------
// sbp_emit
// Result register: walks the sixteen channels of a frame, or gives one reject.
// ----------------------------------------------------------------------------
module sbp_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  sbp_pkg::frame_type   frame,
   output logic                 emit_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_status,
   output logic [3:0]           rsp_channel_index,
   output logic [10:0]          rsp_channel_value,
   output logic                 rsp_failsafe_flag,
   output logic                 rsp_frame_lost_flag,
   output logic                 rsp_last
);
   import sbp_pkg::*;

   logic                    busy_ff, busy_in;
   logic [ChanIdxBits-1:0]  count_ff, count_in;
   logic                    reject_ff, reject_in;
   logic                    fs_ff, fs_in;
   logic                    fl_ff, fl_in;
   logic [ChanDataBits-1:0] data_ff, data_in;
   logic                    last;

   assign last = reject_ff || (count_ff == LastChan);

   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      reject_in = reject_ff;
      fs_in     = fs_ff;
      fl_in     = fl_ff;
      data_in   = data_ff;
      if (frame.load) begin
         busy_in   = 1'b1;
         count_in  = '0;
         reject_in = frame.reject;
         // A rejected frame reports zero for every payload field.
         fs_in     = frame.failsafe && !frame.reject;
         fl_in     = frame.link_lost && !frame.reject;
         data_in   = frame.reject ? '0 : frame.data;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + ChanIdxBits'(1);
            data_in  = data_ff >> ChanBits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff  <= count_in;
      reject_ff <= reject_in;
      fs_ff     <= fs_in;
      fl_ff     <= fl_in;
      data_ff   <= data_in;
   end

   assign emit_busy           = busy_ff;
   assign rsp_valid           = busy_ff;
   assign rsp_status          = reject_ff;
   assign rsp_channel_index   = count_ff;
   assign rsp_channel_value   = data_ff[ChanBits-1:0];
   assign rsp_failsafe_flag   = fs_ff;
   assign rsp_frame_lost_flag = fl_ff;
   assign rsp_last            = last;

`ifndef SYNTH
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      frame.load |-> !busy_ff)
      else $error("frame loaded while results still pending");
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_channel_index == '0
         && rsp_channel_value == '0)
      else $error("reject result malformed");
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_channel_index == $past(rsp_channel_index) + 4'd1)
      else $error("channel index did not advance");
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         $stable(rsp_failsafe_flag) && $stable(rsp_frame_lost_flag))
      else $error("frame flags changed within a frame");
`endif

endmodule

@@ hw/rtl/sbus_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// sbus_frame_parser_core
// Byte-serial decoder for 16-channel frames of packed 11-bit servo values.
// ----------------------------------------------------------------------------
// Usage: received serial bytes enter on the req_ channel, one word per byte.
// Bytes are dropped until the header 0x0f; the next 23 bytes are stored and
// the 24th is the footer. A good footer yields sixteen words on the rsp_
// channel (channel 0..15, flags from the flag byte, rsp_last on channel 15);
// a bad footer yields one word with rsp_status set and rsp_last set.
// Latency: the first result is valid the cycle after the footer is taken.
// Throughput: one byte per cycle. Results leave at one per cycle when
// rsp_ready is high; data bytes of the next frame are still taken meanwhile,
// and only a footer waits (req_ready low) until the previous frame's last
// result has been accepted.
// Reset (synchronous, active high) returns the block to header search and
// drops any results not yet delivered. A stalled receiver simply holds the
// current result; nothing is lost.
// ----------------------------------------------------------------------------
module sbus_frame_parser_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_status,
   output logic [3:0]   rsp_channel_index,
   output logic [10:0]  rsp_channel_value,
   output logic         rsp_failsafe_flag,
   output logic         rsp_frame_lost_flag,
   output logic         rsp_last
);
   import sbp_pkg::*;

   frame_type frame;
   logic      emit_busy;

   sbp_frame_asm u_asm (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .emit_busy   (emit_busy),
      .frame       (frame)
   );

   sbp_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .frame               (frame),
      .emit_busy           (emit_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_failsafe_flag   (rsp_failsafe_flag),
      .rsp_frame_lost_flag (rsp_frame_lost_flag),
      .rsp_last            (rsp_last)
   );

endmodule

@@ dv/sbus_frame_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// sbus_frame_parser_core_tb
// Checks the servo frame parser word by word against a behavioral decoder.
// ----------------------------------------------------------------------------
// A short table of frames covers the extremes, every footer, a header byte
// inside a frame and bad footers. Random frames with random content, noise
// and cut-short frames follow. Each accepted byte runs through a decoder in
// the bench, and each result word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module sbus_frame_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbp_pkg::*;

   localparam int RandomBytes = 115;
   localparam int StallLimit  = 1000;
   localparam int DrainCycles = 20;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_REJECT,
      CHK_FLAT
   } frame_check_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  index;
      logic [10:0] value;
      logic        failsafe;
      logic        link_lost;
      logic        last;
   } chan_word_type;

   // Data byte i of a frame is fill + step * i; byte 22 is the flag byte.
   typedef struct packed {
      logic [7:0]      lead;
      logic [7:0]      fill;
      logic [7:0]      step;
      logic [7:0]      flags;
      logic [7:0]      footer;
      frame_check_type check;
      logic [10:0]     value;
      logic            failsafe;
      logic            link_lost;
   } frame_row_type;

   localparam frame_row_type DirectedFrames [8] = '{
      '{8'h00, 8'hff, 8'h00, 8'hff, FooterA, CHK_FLAT, 11'h7ff, 1'b1, 1'b1},
      '{8'hff, 8'h00, 8'h00, 8'h00, FooterB, CHK_FLAT, 11'h000, 1'b0, 1'b0},
      '{8'h0e, HeaderByte, 8'h00, 8'h08, FooterC, CHK_MODEL, 11'h0, 1'b0, 1'b0},
      '{8'h10, 8'h01, 8'h13, 8'h04, FooterD, CHK_MODEL, 11'h0, 1'b0, 1'b0},
      '{8'h80, 8'h5a, 8'h25, 8'hf3, FooterA, CHK_MODEL, 11'h0, 1'b0, 1'b0},
      '{8'h00, 8'hff, 8'h00, 8'hff, 8'hff, CHK_REJECT, 11'h0, 1'b0, 1'b0},
      '{8'h7f, 8'ha5, 8'h00, 8'h0c, 8'h00, CHK_REJECT, 11'h0, 1'b0, 1'b0},
      '{8'h01, 8'h3c, 8'h07, 8'h00, HeaderByte, CHK_REJECT, 11'h0, 1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [3:0]  rsp_channel_index;
   logic [10:0] rsp_channel_value;
   logic        rsp_failsafe_flag;
   logic        rsp_frame_lost_flag;
   logic        rsp_last;

   // Decoder state of the bench.
   logic             framing = 1'b0;
   logic [4:0]       frame_pos = '0;
   logic [7:0]       frame_bytes [StoreBytes];

   chan_word_type    pending_words [$];
   int               mismatches = 0;
   int               req_gap_pct = 24;
   int               rsp_stall_pct = 53;
   int               idle_cycles = 0;

   sbus_frame_parser_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_failsafe_flag   (rsp_failsafe_flag),
      .rsp_frame_lost_flag (rsp_frame_lost_flag),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Advances the bench decoder by one byte and returns the words it causes.
   function automatic void decode_byte(input logic [7:0] b,
                                       output chan_word_type words [NumChan],
                                       output int count);
      logic [ChanDataBits-1:0] stream;
      logic [7:0]              flag_byte;
      count = 0;
      if (!framing) begin
         if (b == HeaderByte) begin
            framing = 1'b1;
            frame_pos = '0;
         end
      end else if (frame_pos != FooterPos) begin
         frame_bytes[frame_pos] = b;
         frame_pos = frame_pos + 5'd1;
      end else begin
         framing = 1'b0;
         if (b == FooterA || b == FooterB || b == FooterC || b == FooterD) begin
            // Channels are consecutive 11-bit slices of one little-endian stream.
            for (int i = 0; i < ChanBytes; i++) begin
               stream[8*i +: 8] = frame_bytes[i];
            end
            flag_byte = frame_bytes[ChanBytes];
            for (int k = 0; k < NumChan; k++) begin
               words[k] = '{1'b0, 4'(k), stream[ChanBits*k +: ChanBits],
                            flag_byte[FailsafeBit], flag_byte[FrameLostBit],
                            k == NumChan - 1};
            end
            count = NumChan;
         end else begin
            words[0] = '{1'b1, 4'd0, 11'd0, 1'b0, 1'b0, 1'b1};
            count = 1;
         end
      end
   endfunction

   // Offers one word, waits until it is taken, then queues what it should cause.
   task automatic send_byte(input logic [7:0] b, input frame_check_type check,
                            input logic [10:0] value, input logic failsafe,
                            input logic link_lost);
      chan_word_type words [NumChan];
      int            count;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, words, count);
      case (check)
         CHK_MODEL: begin
            for (int k = 0; k < count; k++) pending_words.push_back(words[k]);
         end
         CHK_REJECT: begin
            pending_words.push_back('{1'b1, 4'd0, 11'd0, 1'b0, 1'b0, 1'b1});
         end
         CHK_FLAT: begin
            for (int k = 0; k < NumChan; k++) begin
               pending_words.push_back('{1'b0, 4'(k), value, failsafe, link_lost,
                                         k == NumChan - 1});
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_model_byte(input logic [7:0] b);
      send_byte(b, CHK_MODEL, 11'd0, 1'b0, 1'b0);
   endtask

   // Holds the sender off until every expected word has come back.
   task automatic drain_results();
      if (pending_words.size() != 0) begin
         req_valid <= 1'b0;
         while (pending_words.size() != 0) @(posedge clock);
      end
   endtask

   // Result checker and receiver back-pressure.
   always @(posedge clock) begin
      chan_word_type got;
      chan_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_channel_index, rsp_channel_value, rsp_failsafe_flag,
                 rsp_frame_lost_flag, rsp_last};
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", got));
         end else begin
            want = pending_words.pop_front();
            check_field("status", got.status, want.status);
            check_field("channel_index", got.index, want.index);
            check_field("channel_value", got.value, want.value);
            check_field("failsafe_flag", got.failsafe, want.failsafe);
            check_field("frame_lost_flag", got.link_lost, want.link_lost);
            check_field("last", got.last, want.last);
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // Ends a hung run: counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int             sent;
      int             body_len;
      logic [7:0]     b;
      frame_row_type  row;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedFrames[r]) begin
         row = DirectedFrames[r];
         send_model_byte(row.lead);
         send_model_byte(HeaderByte);
         for (int i = 0; i < ChanBytes; i++) begin
            send_model_byte(row.fill + row.step * 8'(i));
         end
         send_model_byte(row.flags);
         send_byte(row.footer, row.check, row.value, row.failsafe, row.link_lost);
      end
      drain_results();

      sent = 0;
      while (sent < RandomBytes) begin
         if (sent >= 2 * RandomBytes / 3 && req_gap_pct != 0) begin
            drain_results();
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else if (sent >= RandomBytes / 3 && req_gap_pct == 24) begin
            drain_results();
            req_gap_pct = 53;
            rsp_stall_pct = 24;
         end

         // Line noise between frames; a stray header here opens a frame early.
         repeat ($urandom_range(3)) send_model_byte(8'($urandom_range(255)));
         send_model_byte(HeaderByte);
         // One frame in eight is cut short, so the bytes that follow land in the open frame.
         body_len = ($urandom_range(7) == 0) ? $urandom_range(StoreBytes - 1) : StoreBytes;
         for (int i = 0; i < body_len; i++) begin
            b = ($urandom_range(15) == 0) ? HeaderByte : 8'($urandom_range(255));
            send_model_byte(b);
         end
         sent += body_len + 1;
         if (body_len == StoreBytes) begin
            if ($urandom_range(4) != 0) begin
               case ($urandom_range(3))
                  0: b = FooterA;
                  1: b = FooterB;
                  2: b = FooterC;
                  default: b = FooterD;
               endcase
            end else begin
               b = 8'($urandom_range(255));
            end
            send_model_byte(b);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
